### rtl/rcg_pkg.sv
// Shared types and constants for the Roberts cross gradient core.
// Used by rcg_ctrl, rcg_datapath and the top level; depends on nothing.

package rcg_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Field widths and reset values of the configuration registers.
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 12;
    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd450;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 12'd300;

    // APB port sizes.
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register indexes, taken from paddr[2].
    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_SQUARE,
        ST_ROOT,
        ST_OUT
    } t_state;

    // Which 2x2 window a result is taken from.
    typedef enum logic [1:0] {
        KIND_CENTER,
        KIND_RIGHT,
        KIND_BELOW,
        KIND_CORNER
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  accept;
        logic  capture_up;
        logic  load_diff;
        logic  load_square;
        logic  root_step;
        logic  load_out;
        logic  last;
        t_kind kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit_any;
        logic last_col;
        logic last_row;
        logic out_free;
    } t_status;

endpackage

### rtl/rcg_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.

module rcg_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/rcg_ctrl.sv
// Controller state machine: sequences pixel acceptance, line store read and
// the per-result difference, square and square root steps. Uses rcg_pkg.

module rcg_ctrl #(
    parameter int PIXEL_BITS = rcg_pkg::PIXEL_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pixel_valid,
    output logic             o_pixel_ready,
    input  rcg_pkg::t_status i_status,
    output rcg_pkg::t_cmd    o_cmd
);

    localparam int ROOT_STEPS = PIXEL_BITS + 1;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    rcg_pkg::t_state r_state, n_state;
    rcg_pkg::t_kind  r_kind, n_kind, w_next_kind;
    logic [STEP_W-1:0] r_step, n_step;
    logic w_has_next;
    logic w_root_done;

    assign w_root_done = (r_step == STEP_W'(ROOT_STEPS - 1));

    // Which result follows the current one within the same pixel.
    always_comb begin
        w_next_kind = rcg_pkg::KIND_CENTER;
        w_has_next  = 1'b0;
        case (r_kind)
            rcg_pkg::KIND_CENTER: begin
                if (i_status.last_col) begin
                    w_next_kind = rcg_pkg::KIND_RIGHT;
                    w_has_next  = 1'b1;
                end else if (i_status.last_row) begin
                    w_next_kind = rcg_pkg::KIND_BELOW;
                    w_has_next  = 1'b1;
                end
            end
            rcg_pkg::KIND_RIGHT: begin
                if (i_status.last_row) begin
                    w_next_kind = rcg_pkg::KIND_BELOW;
                    w_has_next  = 1'b1;
                end
            end
            rcg_pkg::KIND_BELOW: begin
                if (i_status.last_col) begin
                    w_next_kind = rcg_pkg::KIND_CORNER;
                    w_has_next  = 1'b1;
                end
            end
            default: begin
                w_has_next = 1'b0;
            end
        endcase
    end

    // Next state, result kind and root step count.
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_step  = r_step;
        case (r_state)
            rcg_pkg::ST_IDLE: begin
                if (i_pixel_valid) begin
                    n_state = rcg_pkg::ST_READ;
                end
            end
            rcg_pkg::ST_READ: begin
                n_kind  = rcg_pkg::KIND_CENTER;
                n_state = i_status.emit_any ? rcg_pkg::ST_DIFF : rcg_pkg::ST_IDLE;
            end
            rcg_pkg::ST_DIFF: begin
                n_state = rcg_pkg::ST_SQUARE;
            end
            rcg_pkg::ST_SQUARE: begin
                n_step  = '0;
                n_state = rcg_pkg::ST_ROOT;
            end
            rcg_pkg::ST_ROOT: begin
                n_step = r_step + STEP_W'(1);
                if (w_root_done) begin
                    n_state = rcg_pkg::ST_OUT;
                end
            end
            rcg_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    if (w_has_next) begin
                        n_kind  = w_next_kind;
                        n_state = rcg_pkg::ST_DIFF;
                    end else begin
                        n_state = rcg_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = rcg_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd         = '0;
        o_cmd.kind    = r_kind;
        o_cmd.last    = !w_has_next;
        o_pixel_ready = 1'b0;
        case (r_state)
            rcg_pkg::ST_IDLE: begin
                o_pixel_ready = 1'b1;
                o_cmd.accept  = i_pixel_valid;
            end
            rcg_pkg::ST_READ: begin
                o_cmd.capture_up = 1'b1;
            end
            rcg_pkg::ST_DIFF: begin
                o_cmd.load_diff = 1'b1;
            end
            rcg_pkg::ST_SQUARE: begin
                o_cmd.load_square = 1'b1;
            end
            rcg_pkg::ST_ROOT: begin
                o_cmd.root_step = 1'b1;
            end
            rcg_pkg::ST_OUT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_pixel_ready = 1'b0;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcg_pkg::ST_IDLE;
            r_kind  <= rcg_pkg::KIND_CENTER;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_step  <= n_step;
        end
    end

endmodule

### rtl/rcg_datapath.sv
// Datapath: position counters, neighbor registers, line store, difference and
// square stages, bit-serial square root and the output register.
// Uses rcg_pkg and rcg_ram.

module rcg_datapath #(
    parameter int MAX_WIDTH  = rcg_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = rcg_pkg::PIXEL_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [PIXEL_BITS-1:0]                  i_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]           i_last_col_idx,
    input  logic [rcg_pkg::HEIGHT_REG_BITS-1:0]    i_last_row_idx,
    input  rcg_pkg::t_cmd                          i_cmd,
    output rcg_pkg::t_status                       o_status,
    input  logic                                   i_result_ready,
    output logic                                   o_result_valid,
    output logic signed [PIXEL_BITS:0]             o_grad_diag,
    output logic signed [PIXEL_BITS:0]             o_grad_anti,
    output logic [PIXEL_BITS:0]                    o_magnitude,
    output logic                                   o_last_of_run,
    output logic                                   o_end_of_frame
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int ROWW  = rcg_pkg::HEIGHT_REG_BITS;
    localparam int GW    = PIXEL_BITS + 1;
    localparam int RADW  = 2 * GW;
    localparam int REMW  = PIXEL_BITS + 3;

    // Position and neighbor state.
    logic [CW-1:0]         r_col;
    logic [ROWW-1:0]       r_row;
    logic [PIXEL_BITS-1:0] r_prev_cur;
    logic [PIXEL_BITS-1:0] r_prev_prev;

    // Latched window operands and flags of the pixel in flight.
    logic [PIXEL_BITS-1:0] r_cur, r_up, r_pc, r_pp;
    logic [CW-1:0]         r_wr_col;
    logic                  r_emit_any, r_last_col, r_last_row;

    logic [PIXEL_BITS-1:0] w_rd_data;
    logic                  w_last_col, w_last_row;

    // Difference, square and root stages.
    logic [PIXEL_BITS-1:0]   w_a, w_b, w_c, w_d;
    logic signed [GW-1:0]    r_g1, r_g2;
    logic signed [RADW-1:0]  w_sq1, w_sq2;
    logic [RADW-1:0]         r_rad;
    logic [REMW-1:0]         r_rem;
    logic [GW-1:0]           r_root;
    logic [REMW-1:0]         w_rem_sh, w_trial;

    // Output register.
    logic                    r_out_valid;
    logic signed [GW-1:0]    r_out_diag, r_out_anti;
    logic [GW-1:0]           r_out_mag;
    logic                    r_out_last, r_out_eof;

    assign w_last_col = (r_col >= i_last_col_idx);
    assign w_last_row = (r_row >= i_last_row_idx);

    // Line store holding the previous row; read at the accept edge, written next cycle.
    rcg_ram #(
        .DATA_W (PIXEL_BITS),
        .DEPTH  (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.capture_up),
        .i_wr_addr (r_wr_col),
        .i_wr_data (r_cur),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd_data)
    );

    // Raster position and the left neighbors in both rows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_prev_cur  <= '0;
            r_prev_prev <= '0;
            r_emit_any  <= 1'b0;
            r_last_col  <= 1'b0;
            r_last_row  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_prev_cur <= i_pixel;
                r_emit_any <= (r_row != '0) && (r_col != '0);
                r_last_col <= w_last_col;
                r_last_row <= w_last_row;
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : r_row + ROWW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (i_cmd.capture_up) begin
                r_prev_prev <= w_rd_data;
            end
        end
    end

    // Window operands of the pixel in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur    <= i_pixel;
            r_pc     <= r_prev_cur;
            r_pp     <= r_prev_prev;
            r_wr_col <= r_col;
        end
        if (i_cmd.capture_up) begin
            r_up <= w_rd_data;
        end
    end

    // Operand selection: the window reflects into the previous row or column at the border.
    always_comb begin
        w_a = r_pp;
        w_b = r_cur;
        w_c = r_up;
        w_d = r_pc;
        case (i_cmd.kind)
            rcg_pkg::KIND_CENTER: begin
                w_a = r_pp;  w_b = r_cur; w_c = r_up;  w_d = r_pc;
            end
            rcg_pkg::KIND_RIGHT: begin
                w_a = r_up;  w_b = r_pc;  w_c = r_pp;  w_d = r_cur;
            end
            rcg_pkg::KIND_BELOW: begin
                w_a = r_pc;  w_b = r_up;  w_c = r_cur; w_d = r_pp;
            end
            rcg_pkg::KIND_CORNER: begin
                w_a = r_cur; w_b = r_pp;  w_c = r_pc;  w_d = r_up;
            end
            default: begin
                w_a = r_pp;
            end
        endcase
    end

    assign w_sq1 = RADW'(r_g1) * RADW'(r_g1);
    assign w_sq2 = RADW'(r_g2) * RADW'(r_g2);

    // Restoring square root, one result bit per step.
    assign w_rem_sh = {r_rem[REMW-3:0], r_rad[RADW-1:RADW-2]};
    assign w_trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_diff) begin
            r_g1 <= $signed({1'b0, w_a}) - $signed({1'b0, w_b});
            r_g2 <= $signed({1'b0, w_c}) - $signed({1'b0, w_d});
        end
        if (i_cmd.load_square) begin
            r_rad  <= $unsigned(w_sq1 + w_sq2);
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.root_step) begin
            r_rad <= {r_rad[RADW-3:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[GW-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[GW-2:0], 1'b0};
            end
        end
    end

    // Output register: holds a finished result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_result_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_diag <= r_g1;
            r_out_anti <= r_g2;
            r_out_mag  <= r_root;
            r_out_last <= i_cmd.last;
            r_out_eof  <= (i_cmd.kind == rcg_pkg::KIND_CORNER);
        end
    end

    always_comb begin
        o_status          = '0;
        o_status.emit_any = r_emit_any;
        o_status.last_col = r_last_col;
        o_status.last_row = r_last_row;
        o_status.out_free = !r_out_valid || i_result_ready;
    end

    assign o_result_valid = r_out_valid;
    assign o_grad_diag    = r_out_diag;
    assign o_grad_anti    = r_out_anti;
    assign o_magnitude    = r_out_mag;
    assign o_last_of_run  = r_out_last;
    assign o_end_of_frame = r_out_eof;

endmodule

### rtl/roberts_cross_gradient_magnitude_core.sv
// Roberts cross gradient magnitude core, top level with the APB register file.
// Depends on rcg_pkg, rcg_ram, rcg_ctrl and rcg_datapath.
//
// Pixels enter in raster order, one request at a time; each pixel at row r >= 1
// and column c >= 1 releases the result for (r-1, c-1), plus the right border result
// on the last column and the bottom row results on the last row, so one pixel gives
// zero to four results. A pixel releasing nothing visits only the idle and read states;
// each result visits the difference, square, square root and output states, the bit-serial
// square root unit producing one magnitude bit per cycle. The output register lets the next
// pixel be accepted while the last result still waits to be taken. The line store needs no
// clearing after reset. Width and height are written over APB at addresses 0 and 4; the
// user must write them only while the core is idle, since the core does not enforce it.

module roberts_cross_gradient_magnitude_core #(
    parameter int MAX_WIDTH  = rcg_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = rcg_pkg::PIXEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rcg_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [rcg_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [rcg_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    // Pixel input
    input  logic                                i_pixel_valid,
    output logic                                o_pixel_ready,
    input  logic [PIXEL_BITS-1:0]               i_pixel,
    // Result output
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output logic signed [PIXEL_BITS:0]          o_grad_diag,
    output logic signed [PIXEL_BITS:0]          o_grad_anti,
    output logic [PIXEL_BITS:0]                 o_magnitude,
    output logic                                o_last_of_run,
    output logic                                o_end_of_frame
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WRB  = rcg_pkg::WIDTH_REG_BITS;
    localparam int HRB  = rcg_pkg::HEIGHT_REG_BITS;
    localparam int WCMP = (CW + 1 > WRB) ? CW + 1 : WRB;
    localparam int DW   = rcg_pkg::APB_DATA_BITS;
    localparam int AW   = rcg_pkg::APB_ADDR_BITS;

    logic [WRB-1:0]  r_image_width;
    logic [HRB-1:0]  r_image_height;
    logic            w_cfg_write;
    logic [WCMP-1:0] w_width_ext, w_width_eff;
    logic [HRB-1:0]  w_height_eff;
    logic [CW-1:0]   w_last_col_idx;
    logic [HRB-1:0]  w_last_row_idx;

    rcg_pkg::t_cmd    w_cmd;
    rcg_pkg::t_status w_status;

    // Register writes complete in the access phase.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= rcg_pkg::WIDTH_RESET;
            r_image_height <= rcg_pkg::HEIGHT_RESET;
        end else if (w_cfg_write) begin
            case (paddr[AW-1:2])
                rcg_pkg::REG_IMAGE_WIDTH:  r_image_width  <= pwdata[WRB-1:0];
                rcg_pkg::REG_IMAGE_HEIGHT: r_image_height <= pwdata[HRB-1:0];
                default: begin
                    r_image_width <= r_image_width;
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[AW-1:2])
            rcg_pkg::REG_IMAGE_WIDTH:  prdata = DW'(r_image_width);
            rcg_pkg::REG_IMAGE_HEIGHT: prdata = DW'(r_image_height);
            default:                   prdata = '0;
        endcase
    end

    // Clamp the frame size and derive the last column and row indexes.
    assign w_width_ext = WCMP'(r_image_width);

    always_comb begin
        if (w_width_ext < WCMP'(2)) begin
            w_width_eff = WCMP'(2);
        end else if (w_width_ext > WCMP'(MAX_WIDTH)) begin
            w_width_eff = WCMP'(MAX_WIDTH);
        end else begin
            w_width_eff = w_width_ext;
        end
        w_height_eff = (r_image_height < HRB'(2)) ? HRB'(2) : r_image_height;
    end

    assign w_last_col_idx = CW'(w_width_eff - WCMP'(1));
    assign w_last_row_idx = w_height_eff - HRB'(1);

    rcg_ctrl #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    rcg_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel        (i_pixel),
        .i_last_col_idx (w_last_col_idx),
        .i_last_row_idx (w_last_row_idx),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_result_ready (i_result_ready),
        .o_result_valid (o_result_valid),
        .o_grad_diag    (o_grad_diag),
        .o_grad_anti    (o_grad_anti),
        .o_magnitude    (o_magnitude),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for roberts_cross_gradient_magnitude_core: pixel frames, APB size writes,
// and a built-in gradient predictor that every result request is checked against.
// Depends on rcg_pkg and the core RTL; reads no files.

module testbench;

    localparam int PIX_W         = rcg_pkg::PIXEL_BITS_DEF;
    localparam int LINE_DEPTH    = rcg_pkg::MAX_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_PIXELS = 190;
    localparam int FILL_PIXELS   = 24;
    localparam int HOLD_AT       = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [rcg_pkg::APB_ADDR_BITS-1:0] ADDR_WIDTH  =
        {rcg_pkg::REG_IMAGE_WIDTH, 2'b00};
    localparam logic [rcg_pkg::APB_ADDR_BITS-1:0] ADDR_HEIGHT =
        {rcg_pkg::REG_IMAGE_HEIGHT, 2'b00};

    // One gradient result as the core presents it.
    typedef struct packed {
        logic signed [PIX_W:0] diag;
        logic signed [PIX_W:0] anti;
        logic [PIX_W:0]        mag;
        logic                  last;
        logic                  eof;
    } t_grad_res;

    // One row of the directed pixel table.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             typed;
        logic [2:0]       n_typed;
    } t_dir_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [rcg_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [rcg_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [rcg_pkg::APB_DATA_BITS-1:0] prdata;
    logic                              pready;
    logic                              i_pixel_valid;
    logic                              o_pixel_ready;
    logic [PIX_W-1:0]                  i_pixel;
    logic                              o_result_valid;
    logic                              i_result_ready;
    logic signed [PIX_W:0]             o_grad_diag;
    logic signed [PIX_W:0]             o_grad_anti;
    logic [PIX_W:0]                    o_magnitude;
    logic                              o_last_of_run;
    logic                              o_end_of_frame;

    // Predictor state: frame size registers, line buffer, neighbors and raster position.
    logic [rcg_pkg::WIDTH_REG_BITS-1:0]  cfg_width;
    logic [rcg_pkg::HEIGHT_REG_BITS-1:0] cfg_height;
    logic [PIX_W-1:0]                    line_mem [LINE_DEPTH];
    logic [PIX_W-1:0]                    left_cur;
    logic [PIX_W-1:0]                    left_up;
    logic [9:0]                          col_q;
    logic [11:0]                         row_q;
    t_grad_res                           pending_grads [$];

    int               mismatch_count = 0;
    int               results_taken  = 0;
    int               quiet_cycles   = 0;
    int               send_burst     = 0;
    int               recv_burst     = 0;
    logic [PIX_W-1:0] last_pix       = '0;

    // Directed frames at 2x2: a corner impulse, the largest magnitude, a flat frame, another
    // corner impulse, then one frame left to the predictor.
    t_dir_row dir_rows [20] = '{
        '{8'd255, 1'b1, 3'd0}, '{8'd0,   1'b1, 3'd0}, '{8'd0,   1'b1, 3'd0},
        '{8'd0,   1'b1, 3'd4},
        '{8'd0,   1'b1, 3'd0}, '{8'd255, 1'b1, 3'd0}, '{8'd0,   1'b1, 3'd0},
        '{8'd255, 1'b1, 3'd4},
        '{8'd0,   1'b1, 3'd0}, '{8'd0,   1'b1, 3'd0}, '{8'd0,   1'b1, 3'd0},
        '{8'd0,   1'b1, 3'd4},
        '{8'd0,   1'b1, 3'd0}, '{8'd0,   1'b1, 3'd0}, '{8'd255, 1'b1, 3'd0},
        '{8'd0,   1'b1, 3'd4},
        '{8'd17,  1'b0, 3'd0}, '{8'd200, 1'b0, 3'd0}, '{8'd90,  1'b0, 3'd0},
        '{8'd3,   1'b0, 3'd0}
    };

    // Results of the typed rows above, in order: center, right border, bottom border, corner.
    t_grad_res typed_res [16] = '{
        '{9'sd255,  9'sd0,    9'd255, 1'b0, 1'b0}, '{9'sd0,    9'sd255,  9'd255, 1'b0, 1'b0},
        '{9'sd0,    -9'sd255, 9'd255, 1'b0, 1'b0}, '{-9'sd255, 9'sd0,    9'd255, 1'b1, 1'b1},
        '{-9'sd255, 9'sd255,  9'd360, 1'b0, 1'b0}, '{9'sd255,  -9'sd255, 9'd360, 1'b0, 1'b0},
        '{-9'sd255, 9'sd255,  9'd360, 1'b0, 1'b0}, '{9'sd255,  -9'sd255, 9'd360, 1'b1, 1'b1},
        '{9'sd0,    9'sd0,    9'd0,   1'b0, 1'b0}, '{9'sd0,    9'sd0,    9'd0,   1'b0, 1'b0},
        '{9'sd0,    9'sd0,    9'd0,   1'b0, 1'b0}, '{9'sd0,    9'sd0,    9'd0,   1'b1, 1'b1},
        '{9'sd0,    -9'sd255, 9'd255, 1'b0, 1'b0}, '{-9'sd255, 9'sd0,    9'd255, 1'b0, 1'b0},
        '{9'sd255,  9'sd0,    9'd255, 1'b0, 1'b0}, '{9'sd0,    9'sd255,  9'd255, 1'b1, 1'b1}
    };

    roberts_cross_gradient_magnitude_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_ready  (o_pixel_ready),
        .i_pixel        (i_pixel),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_grad_diag    (o_grad_diag),
        .o_grad_anti    (o_grad_anti),
        .o_magnitude    (o_magnitude),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Idle length for either side: mostly none or short, a few long, with bursts of none.
    function automatic int idle_len(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 3) begin
            burst = int'($urandom_range(20, 60));
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 50));
    endfunction

    // Pixel source: extremes, smooth runs near the last value, and uniform noise.
    function automatic logic [PIX_W-1:0] next_pixel();
        int r;
        int v;
        r = int'($urandom_range(0, 9));
        if (r < 2) begin
            v = ($urandom_range(0, 1) != 0) ? 255 : 0;
        end else if (r < 5) begin
            v = int'(last_pix) + int'($urandom_range(0, 24)) - 12;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
        end else begin
            v = int'($urandom_range(0, 255));
        end
        last_pix = v[PIX_W-1:0];
        return v[PIX_W-1:0];
    endfunction

    function automatic int floor_sqrt(int s);
        int r = 0;
        while ((r + 1) * (r + 1) <= s) r++;
        return r;
    endfunction

    // Both cross differences of one 2x2 window and their magnitude.
    function automatic t_grad_res cross_pair(logic [PIX_W-1:0] tl, logic [PIX_W-1:0] br,
                                             logic [PIX_W-1:0] tr, logic [PIX_W-1:0] bl,
                                             bit eof);
        t_grad_res g;
        int d1;
        int d2;
        int m;
        d1 = int'(tl) - int'(br);
        d2 = int'(tr) - int'(bl);
        m = floor_sqrt(d1 * d1 + d2 * d2);
        g.diag = d1[PIX_W:0];
        g.anti = d2[PIX_W:0];
        g.mag  = m[PIX_W:0];
        g.last = 1'b0;
        g.eof  = eof;
        return g;
    endfunction

    // Advance the predictor by one accepted pixel; queue its results when keep is set.
    task automatic roberts_predict(input logic [PIX_W-1:0] pix, input bit keep);
        t_grad_res        res [4];
        int               n;
        int               eff_w;
        int               eff_h;
        bit               at_right;
        bit               at_bottom;
        logic [PIX_W-1:0] above;
        n = 0;
        eff_w = int'(cfg_width);
        if (eff_w < 2) eff_w = 2;
        if (eff_w > LINE_DEPTH) eff_w = LINE_DEPTH;
        eff_h = int'(cfg_height);
        if (eff_h < 2) eff_h = 2;
        at_right  = int'(col_q) >= eff_w - 1;
        at_bottom = int'(row_q) >= eff_h - 1;
        above = line_mem[col_q];

        // The window above-left of this pixel, then the reflected border windows.
        if (row_q != '0 && col_q != '0) begin
            res[n] = cross_pair(left_up, pix, above, left_cur, 1'b0);
            n++;
            if (at_right) begin
                res[n] = cross_pair(above, left_cur, left_up, pix, 1'b0);
                n++;
            end
            if (at_bottom) begin
                res[n] = cross_pair(left_cur, above, pix, left_up, 1'b0);
                n++;
                if (at_right) begin
                    res[n] = cross_pair(pix, left_up, left_cur, above, 1'b1);
                    n++;
                end
            end
            res[n-1].last = 1'b1;
            if (keep) begin
                for (int k = 0; k < n; k++) pending_grads.push_back(res[k]);
            end
        end

        line_mem[col_q] = pix;
        left_cur = pix;
        left_up  = above;
        if (at_right) begin
            col_q = '0;
            row_q = at_bottom ? '0 : row_q + 1'b1;
        end else begin
            col_q = col_q + 1'b1;
        end
    endtask

    // Offer one pixel request after a random gap and return once it is accepted.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = idle_len(send_burst);
        @(negedge i_clk);
        if (gap > 0) begin
            i_pixel_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_pixel_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (!o_pixel_ready);
    endtask

    task automatic feed_pixels(input int count);
        logic [PIX_W-1:0] pix;
        repeat (count) begin
            pix = next_pixel();
            send_pixel(pix);
            roberts_predict(pix, 1'b1);
        end
    endtask

    task automatic apb_write(input logic [rcg_pkg::APB_ADDR_BITS-1:0] addr,
                             input logic [rcg_pkg::APB_DATA_BITS-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read a register and compare it with what the predictor holds.
    task automatic apb_check(input logic [rcg_pkg::APB_ADDR_BITS-1:0] addr,
                             input logic [rcg_pkg::APB_DATA_BITS-1:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $display("%0t: register at %0d expected %0d, got %0d", $time, addr, want, prdata);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write both size registers with random upper bits, then read them back.
    task automatic set_frame_size(input int w_raw, input int h_raw);
        logic [rcg_pkg::APB_DATA_BITS-1:0] wdata;
        logic [rcg_pkg::APB_DATA_BITS-1:0] hdata;
        wdata = $urandom();
        hdata = $urandom();
        wdata[rcg_pkg::WIDTH_REG_BITS-1:0]  = w_raw[rcg_pkg::WIDTH_REG_BITS-1:0];
        hdata[rcg_pkg::HEIGHT_REG_BITS-1:0] = h_raw[rcg_pkg::HEIGHT_REG_BITS-1:0];
        apb_write(ADDR_WIDTH, wdata);
        apb_write(ADDR_HEIGHT, hdata);
        cfg_width  = wdata[rcg_pkg::WIDTH_REG_BITS-1:0];
        cfg_height = hdata[rcg_pkg::HEIGHT_REG_BITS-1:0];
        apb_check(ADDR_WIDTH, rcg_pkg::APB_DATA_BITS'(cfg_width));
        apb_check(ADDR_HEIGHT, rcg_pkg::APB_DATA_BITS'(cfg_height));
    endtask

    // Stop offering pixels, wait for every expected result, then let the core go quiet.
    task automatic settle();
        @(negedge i_clk);
        i_pixel_valid <= 1'b0;
        while (pending_grads.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input integer want, input integer got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Main stimulus: reset, directed frames, large and tall sizes, then random phases.
    initial begin : stimulus
        int typed_idx;
        int w_raw;
        int h_raw;
        int ew;
        int eh;
        int count;
        int random_sent;
        typed_idx   = 0;
        random_sent = 0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_pixel_valid = 1'b0;
        i_pixel       = '0;
        cfg_width  = rcg_pkg::WIDTH_RESET;
        cfg_height = rcg_pkg::HEIGHT_RESET;
        left_cur   = '0;
        left_up    = '0;
        col_q      = '0;
        row_q      = '0;
        foreach (line_mem[k]) line_mem[k] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers come up at their reset sizes.
        apb_check(ADDR_WIDTH, rcg_pkg::APB_DATA_BITS'(rcg_pkg::WIDTH_RESET));
        apb_check(ADDR_HEIGHT, rcg_pkg::APB_DATA_BITS'(rcg_pkg::HEIGHT_RESET));

        // Smallest frame, walked from the directed table.
        set_frame_size(2, 2);
        foreach (dir_rows[k]) begin
            send_pixel(dir_rows[k].pix);
            roberts_predict(dir_rows[k].pix, !dir_rows[k].typed);
            if (dir_rows[k].typed) begin
                for (int j = 0; j < int'(dir_rows[k].n_typed); j++) begin
                    pending_grads.push_back(typed_res[typed_idx]);
                    typed_idx++;
                end
            end
        end
        settle();

        // Width above the limit; a partial first row that also writes every line store
        // entry the random sizes below can reach.
        set_frame_size(2047, 2);
        feed_pixels(FILL_PIXELS);
        settle();

        // Tallest frame, left part way through so the next sizes land mid-frame.
        set_frame_size(2, 4095);
        feed_pixels(41);
        settle();

        // Zero sizes clamp to 2x2 and end the tall frame early.
        set_frame_size(0, 0);
        feed_pixels(8);
        settle();

        // Random sizes, some phases ending mid-frame.
        while (random_sent < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0:          w_raw = int'($urandom_range(0, 1));
                8, 9:       w_raw = int'($urandom_range(9, FILL_PIXELS));
                default:    w_raw = int'($urandom_range(2, 8));
            endcase
            h_raw = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 1))
                                                : int'($urandom_range(2, 6));
            set_frame_size(w_raw, h_raw);
            ew = (w_raw < 2) ? 2 : w_raw;
            eh = (h_raw < 2) ? 2 : h_raw;
            count = int'($urandom_range(1, 2)) * ew * eh;
            if ($urandom_range(0, 2) == 0) count += int'($urandom_range(1, ew * eh - 1));
            if (count > RANDOM_PIXELS - random_sent) count = RANDOM_PIXELS - random_sent;
            feed_pixels(count);
            random_sent += count;
            settle();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result sink: random stalls, one long hold-off, and a field-by-field compare.
    initial begin : result_sink
        int        gap;
        bit        held;
        t_grad_res want;
        held = 1'b0;
        i_result_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held && results_taken >= HOLD_AT) begin
                held = 1'b1;
                gap = HOLD_CYCLES;
            end else begin
                gap = idle_len(recv_burst);
            end
            if (gap > 0) begin
                i_result_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_result_ready <= 1'b1;
            do @(posedge i_clk); while (!o_result_valid);
            results_taken++;
            if (pending_grads.size() == 0) begin
                $display("%0t: unexpected result: diag %0d anti %0d magnitude %0d",
                         $time, o_grad_diag, o_grad_anti, o_magnitude);
                mismatch_count++;
            end else begin
                want = pending_grads.pop_front();
                check_field("grad_diag", integer'(want.diag), integer'(o_grad_diag));
                check_field("grad_anti", integer'(want.anti), integer'(o_grad_anti));
                check_field("magnitude", integer'(want.mag), integer'(o_magnitude));
                check_field("last_of_run", integer'(want.last), integer'(o_last_of_run));
                check_field("end_of_frame", integer'(want.eof), integer'(o_end_of_frame));
            end
        end
    end

    // Watchdog: too long with no request accepted on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_pixel_valid && o_pixel_ready) || (o_result_valid && i_result_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
